/* rtl/bsrc_pkg.sv */
`default_nettype none
package bsrc_pkg;
    localparam int PROCS       = 8;
    localparam int RESOURCES   = 4;
    localparam int COUNT_WIDTH = 16;
    localparam int PW          = $clog2(PROCS);
    localparam int RW          = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int WORK_WIDTH  = COUNT_WIDTH + PW + 3;

    localparam logic [2:0] REQ_LOAD_MAX   = 3'd0;
    localparam logic [2:0] REQ_LOAD_ALLOC = 3'd1;
    localparam logic [2:0] REQ_LOAD_AVAIL = 3'd2;
    localparam logic [2:0] REQ_CHECK      = 3'd3;
    localparam logic [2:0] REQ_REQUEST    = 3'd4;

    localparam logic [1:0] ST_SAFE   = 2'd0;
    localparam logic [1:0] ST_UNSAFE = 2'd1;
    localparam logic [1:0] ST_DENIED = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  proc;
        logic [1:0]  res;
        logic [15:0] value;
        logic [15:0] amount_0;
        logic [15:0] amount_1;
        logic [15:0] amount_2;
        logic [15:0] amount_3;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] seq_proc;
        logic [2:0] seq_pos;
        logic       last;
    } t_out_item;
endpackage
`default_nettype wire

/* rtl/bsrc_if.sv */
`default_nettype none
interface bsrc_in_if;
    logic                valid;
    logic                ready;
    bsrc_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bsrc_out_if;
    logic                valid;
    logic                ready;
    bsrc_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/bankers_safety_and_request_check.sv */
// Banker's algorithm safety and request checker.
// Input channel i_in carries one item per handshake: a load (max claim,
// allocation or available), a safety check or a resource request.
// Output channel o_out returns results: a safe state gives PROCS items,
// one per position of the safe sequence, last set on the final one; an
// unsafe state or a denied request gives a single item with last set.
// Loads give no result: an available load frees the input the next cycle,
// a max claim or allocation load after its load stage (merge, write back).
// Max claim and allocation sit in RAMs, one row per process (all resources
// of a process side by side), with a registered read. No clearing pass is
// needed: reset clears a row-valid bit per process, an invalid row reads zero.
// A check scans rows in index order, each row in a read state and an
// evaluate state, for at most PROCS passes. An unsafe result is set by the
// last evaluate state, a safe one goes through the emit state first; a
// request first reads and evaluates its own row for the deny test, and a
// denial from it is set by that evaluate state. Results sit in an output
// register, one per cycle while the receiver takes them; while it stalls the
// block holds the result and accepts nothing new. Synchronous reset clears
// the FSM, valid flags and available counts; the tables read back as zero.
`default_nettype none
module bankers_safety_and_request_check (
    input wire logic i_clk,
    input wire logic i_rst_n,
    bsrc_in_if.sink    i_in,
    bsrc_out_if.source o_out
);
    import bsrc_pkg::*;

    localparam int ROW_W = RESOURCES * COUNT_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_ONE  = 3'd4;

    logic [2:0] r_state, n_state;

    // Row RAMs: max claim and allocation, indexed by process.
    logic             ram_we_max, ram_we_alloc;
    logic [PW-1:0]    ram_waddr, ram_raddr;
    logic [ROW_W-1:0] ram_wmax, ram_walloc, max_row_raw, alloc_row_raw;

    bsrc_table_ram #(.DEPTH(PROCS), .WIDTH(ROW_W)) u_max (
        .i_clk(i_clk), .i_we(ram_we_max), .i_waddr(ram_waddr), .i_wdata(ram_wmax),
        .i_raddr(ram_raddr), .o_rdata(max_row_raw));
    bsrc_table_ram #(.DEPTH(PROCS), .WIDTH(ROW_W)) u_alloc (
        .i_clk(i_clk), .i_we(ram_we_alloc), .i_waddr(ram_waddr),
        .i_wdata(ram_walloc), .i_raddr(ram_raddr), .o_rdata(alloc_row_raw));

    logic [PROCS-1:0] r_max_vld, r_alloc_vld;
    logic             r_rd_vld_max, r_rd_vld_alloc;
    logic [COUNT_WIDTH-1:0] r_avail [RESOURCES];

    // Single-entry loads read the row, merge and write back. The row is
    // read while idle at i_in.data.proc; a load stage (r_ld) does the merge.
    logic             r_ld;
    logic [2:0]       r_ld_type;
    logic [PW-1:0]    r_ld_proc;
    logic [RW-1:0]    r_ld_res;
    logic [COUNT_WIDTH-1:0] r_ld_val;

    // Check context.
    logic              r_is_req;
    logic [PW-1:0]     r_req_proc;
    logic [COUNT_WIDTH-1:0] r_req [RESOURCES];
    logic signed [WORK_WIDTH-1:0] r_work [RESOURCES];
    logic [PROCS-1:0]  r_done;
    logic [PW-1:0]     r_order [PROCS];
    logic [PW:0]       r_count;
    logic [PW-1:0]     r_p;
    logic              r_progress;
    logic              r_first;     // first row eval of a request: deny test
    logic [PW-1:0]     r_emit;
    t_out_item         r_out;
    logic              r_out_vld;

    logic [ROW_W-1:0] max_row, alloc_row;
    assign max_row   = r_rd_vld_max   ? max_row_raw   : '0;
    assign alloc_row = r_rd_vld_alloc ? alloc_row_raw : '0;

    logic accept;
    assign i_in.ready = (r_state == S_IDLE) && !r_ld && !r_out_vld;
    assign accept     = i_in.valid && i_in.ready;

    logic in_proc_ok, in_res_ok;
    assign in_proc_ok = ({1'b0, i_in.data.proc} < 4'(PROCS));
    assign in_res_ok  = ({1'b0, i_in.data.res} < 3'(RESOURCES));

    logic [15:0] in_amt [4];
    assign in_amt[0] = i_in.data.amount_0;
    assign in_amt[1] = i_in.data.amount_1;
    assign in_amt[2] = i_in.data.amount_2;
    assign in_amt[3] = i_in.data.amount_3;

    // Row evaluation: need (with request applied on the requesting row).
    logic signed [WORK_WIDTH-1:0] alloc_e [RESOURCES];
    logic signed [WORK_WIDTH-1:0] need_e  [RESOURCES];
    logic fits, deny;
    always_comb begin
        fits = !r_done[r_p];
        deny = 1'b0;
        for (int r = 0; r < RESOURCES; r++) begin
            alloc_e[r] = WORK_WIDTH'(alloc_row[r*COUNT_WIDTH +: COUNT_WIDTH]);
            need_e[r]  = WORK_WIDTH'(max_row[r*COUNT_WIDTH +: COUNT_WIDTH])
                         - alloc_e[r];
            if (r_is_req && r_p == r_req_proc) begin
                // Deny on the stored need, which may be negative.
                if ($signed(WORK_WIDTH'(r_req[r])) > need_e[r] ||
                    r_req[r] > r_avail[r])
                    deny = 1'b1;
                alloc_e[r] = alloc_e[r] + $signed(WORK_WIDTH'(r_req[r]));
                need_e[r]  = need_e[r]  - $signed(WORK_WIDTH'(r_req[r]));
            end
            if (need_e[r] > r_work[r]) fits = 1'b0;
        end
    end

    // Pass bookkeeping for the row under evaluation.
    logic [PW:0] eval_cnt;
    logic        eval_prog, pass_end;
    assign eval_cnt  = r_count + (PW+1)'(fits);
    assign eval_prog = r_progress || fits;
    assign pass_end  = ({1'b0, r_p} == (PW+1)'(PROCS - 1));

    // RAM ports.
    always_comb begin
        ram_raddr    = r_p;
        ram_waddr    = r_ld_proc;
        ram_wmax     = max_row;
        ram_walloc   = alloc_row;
        ram_we_max   = 1'b0;
        ram_we_alloc = 1'b0;
        if (r_state == S_IDLE && !r_ld) ram_raddr = i_in.data.proc[PW-1:0];
        if (r_ld) begin
            ram_wmax[r_ld_res*COUNT_WIDTH +: COUNT_WIDTH]   = r_ld_val;
            ram_walloc[r_ld_res*COUNT_WIDTH +: COUNT_WIDTH] = r_ld_val;
            ram_we_max   = (r_ld_type == REQ_LOAD_MAX);
            ram_we_alloc = (r_ld_type == REQ_LOAD_ALLOC);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) begin
                if (i_in.data.req_type == REQ_CHECK) n_state = S_RD;
                else if (i_in.data.req_type == REQ_REQUEST)
                    n_state = in_proc_ok ? S_RD : S_ONE;
            end
            S_RD:   n_state = S_EVAL;
            S_EVAL: begin
                if (r_first && r_is_req) n_state = deny ? S_ONE : S_RD;
                else if (pass_end && eval_cnt == (PW+1)'(PROCS)) n_state = S_EMIT;
                else if (pass_end && !eval_prog) n_state = S_ONE;
                else n_state = S_RD;
            end
            S_EMIT: if (o_out.ready && r_out_vld && r_out.last) n_state = S_IDLE;
            S_ONE:  if (o_out.ready && r_out_vld) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_vld   <= '0;
            r_alloc_vld <= '0;
            r_ld        <= 1'b0;
            r_out_vld   <= 1'b0;
            r_rd_vld_max   <= 1'b0;
            r_rd_vld_alloc <= 1'b0;
            for (int r = 0; r < RESOURCES; r++) r_avail[r] <= '0;
        end else begin
            r_state <= n_state;
            r_rd_vld_max   <= r_max_vld[ram_raddr];
            r_rd_vld_alloc <= r_alloc_vld[ram_raddr];
            r_ld <= accept && in_proc_ok && in_res_ok &&
                    (i_in.data.req_type == REQ_LOAD_MAX ||
                     i_in.data.req_type == REQ_LOAD_ALLOC);
            if (o_out.ready && r_out_vld && r_state != S_EMIT) r_out_vld <= 1'b0;

            if (r_ld) begin
                if (r_ld_type == REQ_LOAD_MAX)   r_max_vld[r_ld_proc]   <= 1'b1;
                if (r_ld_type == REQ_LOAD_ALLOC) r_alloc_vld[r_ld_proc] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: if (accept) begin
                    r_is_req   <= (i_in.data.req_type == REQ_REQUEST);
                    r_req_proc <= i_in.data.proc[PW-1:0];
                    for (int r = 0; r < RESOURCES; r++) begin
                        r_req[r]  <= COUNT_WIDTH'(in_amt[r]);
                        r_work[r] <= WORK_WIDTH'(r_avail[r]) -
                            ((i_in.data.req_type == REQ_REQUEST) ?
                             WORK_WIDTH'(in_amt[r]) : '0);
                    end
                    r_done     <= '0;
                    r_count    <= '0;
                    r_progress <= 1'b0;
                    r_first    <= 1'b1;
                    r_emit     <= '0;
                    // A request reads its own row first for the deny test.
                    r_p <= (i_in.data.req_type == REQ_REQUEST) ?
                           i_in.data.proc[PW-1:0] : '0;
                    unique case (i_in.data.req_type)
                        REQ_LOAD_MAX, REQ_LOAD_ALLOC: begin
                            r_ld_type <= i_in.data.req_type;
                            r_ld_proc <= i_in.data.proc[PW-1:0];
                            r_ld_res  <= i_in.data.res[RW-1:0];
                            r_ld_val  <= COUNT_WIDTH'(i_in.data.value);
                        end
                        REQ_LOAD_AVAIL: if (in_res_ok)
                            r_avail[i_in.data.res[RW-1:0]] <= COUNT_WIDTH'(i_in.data.value);
                        REQ_REQUEST: if (!in_proc_ok) begin
                            r_out     <= '{status: ST_DENIED, seq_proc: '0,
                                           seq_pos: '0, last: 1'b1};
                            r_out_vld <= 1'b1;
                        end
                        default: ;
                    endcase
                end
                S_EVAL: begin
                    if (r_first && r_is_req) begin
                        r_first <= 1'b0;
                        r_p     <= '0;
                        if (deny) begin
                            r_out     <= '{status: ST_DENIED, seq_proc: '0,
                                           seq_pos: '0, last: 1'b1};
                            r_out_vld <= 1'b1;
                        end
                    end else begin
                        if (fits) begin
                            for (int r = 0; r < RESOURCES; r++)
                                r_work[r] <= r_work[r] + alloc_e[r];
                            r_done[r_p]              <= 1'b1;
                            r_order[r_count[PW-1:0]] <= r_p;
                        end
                        r_count <= eval_cnt;
                        if (pass_end) begin
                            r_p        <= '0;
                            r_progress <= 1'b0;
                            // A pass that finishes nobody leaves the state unsafe.
                            if (eval_cnt != (PW+1)'(PROCS) && !eval_prog) begin
                                r_out     <= '{status: ST_UNSAFE, seq_proc: '0,
                                               seq_pos: '0, last: 1'b1};
                                r_out_vld <= 1'b1;
                            end
                        end else begin
                            r_p        <= r_p + 1'b1;
                            r_progress <= eval_prog;
                        end
                    end
                end
                S_EMIT: if (!r_out_vld || o_out.ready) begin
                    if (!(r_out_vld && r_out.last)) begin
                        r_out <= '{status: ST_SAFE,
                                   seq_proc: 3'(r_order[r_emit]),
                                   seq_pos: 3'(r_emit),
                                   last: ({1'b0, r_emit} == (PW+1)'(PROCS - 1))};
                        r_out_vld <= 1'b1;
                        r_emit    <= r_emit + 1'b1;
                    end else begin
                        r_out_vld <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;
endmodule
`default_nettype wire

/* rtl/bsrc_table_ram.sv */
`default_nettype none
module bsrc_table_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/bsrc_checker.sv */
`default_nettype none
module bsrc_assertions (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire bsrc_pkg::t_out_item i_out_data
);
    import bsrc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output item changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.status != 2'd3)
        else $error("bad status code");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status != ST_SAFE |-> i_out_data.last)
        else $error("single result without last");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while result pending");
endmodule

bind bankers_safety_and_request_check bsrc_assertions u_bsrc_assertions (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_out_data(o_out.data));
`default_nettype wire
